// File: hdl/jtl_pkg.sv
// ----------------------------------------------------------------------------
// JSON token lexer package
// Shared character codes, token kinds, lexer modes, result types and the
// byte classification used by the lexer.
// ----------------------------------------------------------------------------
package jtl_pkg;

    localparam int ResultsMax = 3;

    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_BACKSL   = 8'h5C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LOW_A    = 8'h61;
    localparam logic [7:0] CH_LOW_E    = 8'h65;
    localparam logic [7:0] CH_LOW_F    = 8'h66;
    localparam logic [7:0] CH_LOW_L    = 8'h6C;
    localparam logic [7:0] CH_LOW_R    = 8'h72;
    localparam logic [7:0] CH_LOW_S    = 8'h73;
    localparam logic [7:0] CH_LOW_T    = 8'h74;
    localparam logic [7:0] CH_LOW_U    = 8'h75;

    localparam logic [2:0] KIND_LBRACE   = 3'd0;
    localparam logic [2:0] KIND_RBRACE   = 3'd1;
    localparam logic [2:0] KIND_LBRACKET = 3'd2;
    localparam logic [2:0] KIND_RBRACKET = 3'd3;
    localparam logic [2:0] KIND_COLON    = 3'd4;
    localparam logic [2:0] KIND_COMMA    = 3'd5;
    localparam logic [2:0] KIND_VALUE    = 3'd6;
    localparam logic [2:0] KIND_EOF      = 3'd7;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_STR  = 4'b0010,
        MODE_ESC  = 4'b0100,
        MODE_BARE = 4'b1000
    } jtl_mode_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       has_byte;
        logic [7:0] value_char;
        logic       token_done;
        logic       unterminated;
    } jtl_result_t;

    typedef struct packed {
        jtl_result_t [ResultsMax-1:0] res;
        logic [1:0]                   cnt;
    } jtl_batch_t;

    typedef struct packed {
        logic        emit;
        jtl_result_t res;
        logic        to_str;
        logic        to_bare;
    } jtl_idle_t;

    localparam jtl_result_t RES_CLOSE = '{
        kind: KIND_VALUE, has_byte: 1'b0, value_char: 8'h00,
        token_done: 1'b1, unterminated: 1'b0
    };

    function automatic logic is_value_letter(input logic [7:0] c);
        logic hit;
        case (c) inside
            [CH_ZERO:CH_NINE], CH_MINUS, CH_PLUS, CH_DOT,
            CH_LOW_F, CH_LOW_A, CH_LOW_L, CH_LOW_S,
            CH_LOW_E, CH_LOW_T, CH_LOW_R, CH_LOW_U: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic jtl_result_t value_byte(input logic [7:0] c);
        jtl_result_t r;
        r.kind         = KIND_VALUE;
        r.has_byte     = 1'b1;
        r.value_char   = c;
        r.token_done   = 1'b0;
        r.unterminated = 1'b0;
        return r;
    endfunction

    function automatic jtl_result_t punct(input logic [2:0] kind);
        jtl_result_t r;
        r.kind         = kind;
        r.has_byte     = 1'b0;
        r.value_char   = 8'h00;
        r.token_done   = 1'b1;
        r.unterminated = 1'b0;
        return r;
    endfunction

    // Bare value letters are already lowercase, so the byte passes unchanged.
    function automatic jtl_idle_t idle_byte(input logic [7:0] c);
        jtl_idle_t o;
        o.emit    = 1'b1;
        o.res     = RES_CLOSE;
        o.to_str  = 1'b0;
        o.to_bare = 1'b0;
        case (c) inside
            CH_LBRACE:   o.res = punct(KIND_LBRACE);
            CH_RBRACE:   o.res = punct(KIND_RBRACE);
            CH_LBRACKET: o.res = punct(KIND_LBRACKET);
            CH_RBRACKET: o.res = punct(KIND_RBRACKET);
            CH_COLON:    o.res = punct(KIND_COLON);
            CH_COMMA:    o.res = punct(KIND_COMMA);
            CH_QUOTE:
            begin
                o.emit   = 1'b0;
                o.to_str = 1'b1;
            end
            CH_SPACE, CH_CR, CH_LF, CH_TAB: o.emit = 1'b0;
            default:
            begin
                if (is_value_letter(c))
                begin
                    o.res     = value_byte(c);
                    o.to_bare = 1'b1;
                end
            end
        endcase
        return o;
    endfunction

endpackage

// File: hdl/jtl_decode.sv
// ----------------------------------------------------------------------------
// JSON token lexer decode
// Works out from the current lexer mode and one input byte the next mode and
// the ordered list of up to three results that the byte causes.
// ----------------------------------------------------------------------------
module jtl_decode (
    input  jtl_pkg::jtl_mode_t  mode,
    input  logic [7:0]          data_byte,
    input  logic                end_of_input,
    output jtl_pkg::jtl_mode_t  mode_next,
    output jtl_pkg::jtl_batch_t batch
);

    always_comb
    begin
        jtl_pkg::jtl_idle_t   idle;
        jtl_pkg::jtl_mode_t   m;
        jtl_pkg::jtl_result_t eof_res;
        logic [1:0]           n;

        batch   = '0;
        eof_res = '0;
        n       = 2'd0;
        m       = mode;
        idle    = jtl_pkg::idle_byte(data_byte);

        unique case (mode)
            jtl_pkg::MODE_STR:
            begin
                if (data_byte == jtl_pkg::CH_QUOTE)
                begin
                    m = jtl_pkg::MODE_IDLE;
                    batch.res[n] = jtl_pkg::RES_CLOSE;
                end
                else
                begin
                    if (data_byte == jtl_pkg::CH_BACKSL)
                    begin
                        m = jtl_pkg::MODE_ESC;
                    end
                    batch.res[n] = jtl_pkg::value_byte(data_byte);
                end
                n = n + 2'd1;
            end
            jtl_pkg::MODE_ESC:
            begin
                m = jtl_pkg::MODE_STR;
                batch.res[n] = jtl_pkg::value_byte(data_byte);
                n = n + 2'd1;
            end
            jtl_pkg::MODE_BARE:
            begin
                if (jtl_pkg::is_value_letter(data_byte))
                begin
                    batch.res[n] = jtl_pkg::value_byte(data_byte);
                    n = n + 2'd1;
                end
                else
                begin
                    m = jtl_pkg::MODE_IDLE;
                    batch.res[n] = jtl_pkg::RES_CLOSE;
                    n = n + 2'd1;
                    if (idle.emit)
                    begin
                        batch.res[n] = idle.res;
                        n = n + 2'd1;
                    end
                    if (idle.to_str)
                    begin
                        m = jtl_pkg::MODE_STR;
                    end
                end
            end
            jtl_pkg::MODE_IDLE:
            begin
                if (idle.emit)
                begin
                    batch.res[n] = idle.res;
                    n = n + 2'd1;
                end
                if (idle.to_str)
                begin
                    m = jtl_pkg::MODE_STR;
                end
                else if (idle.to_bare)
                begin
                    m = jtl_pkg::MODE_BARE;
                end
            end
            default:
            begin
                m = jtl_pkg::MODE_IDLE;
            end
        endcase

        if (end_of_input)
        begin
            eof_res              = jtl_pkg::punct(jtl_pkg::KIND_EOF);
            eof_res.unterminated = (m == jtl_pkg::MODE_STR) || (m == jtl_pkg::MODE_ESC);
            if ((m == jtl_pkg::MODE_BARE) && (n != 2'd3))
            begin
                batch.res[n] = jtl_pkg::RES_CLOSE;
                n = n + 2'd1;
            end
            if (n != 2'd3)
            begin
                batch.res[n] = eof_res;
                n = n + 2'd1;
            end
            m = jtl_pkg::MODE_IDLE;
        end

        batch.cnt = n;
        mode_next = m;
    end

endmodule

// File: hdl/jtl_emit.sv
// ----------------------------------------------------------------------------
// JSON token lexer result emitter
// Holds the results of one byte and hands them out one transfer per cycle while
// m_tready is high, marking the last of them with tlast.
// ----------------------------------------------------------------------------
module jtl_emit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  jtl_pkg::jtl_batch_t batch,
    output logic                can_load,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // has_byte, value_char, token_done, unterminated
    output logic [2:0]          m_tuser,   // token_kind
    output logic                m_tlast    // run_last
);

    jtl_pkg::jtl_result_t [jtl_pkg::ResultsMax-1:0] res_reg;
    logic [1:0]                                     cnt_reg;
    logic                                           take;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign take     = m_tvalid && m_tready;
    assign can_load = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= batch.cnt;
        end
        else if (take)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= batch.res;
        end
        else if (take)
        begin
            res_reg[0] <= res_reg[1];
            res_reg[1] <= res_reg[2];
        end
    end

    assign m_tdata = {5'd0, res_reg[0].unterminated, res_reg[0].token_done,
                      res_reg[0].value_char, res_reg[0].has_byte};
    assign m_tuser = res_reg[0].kind;
    assign m_tlast = (cnt_reg == 2'd1);

endmodule

// File: hdl/json_token_lexer.sv
// ----------------------------------------------------------------------------
// JSON token lexer
// Takes JSON text one byte per transfer and gives the tokens it forms:
// punctuation, value bytes with value ends, and an end-of-file token.
//
//   Channel  Direction  tdata                tuser       tlast
//   s_*      in         data_byte            -           end_of_input
//   m_*      out        token result fields  token_kind  run_last
//
// A byte waits in the input register, where it is decoded; its results are
// loaded into the result register once that is free and give zero to three
// transfers, one per cycle while m_tready is high. The result register drains
// at that rate, so bytes enter back to back while each gives at most one result.
// Reset puts the lexer in idle mode with no results pending.
// A stalled result side holds the input register, which then stops taking bytes.
// ----------------------------------------------------------------------------
module json_token_lexer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // has_byte, value_char, token_done, unterminated
    output logic [2:0]  m_tuser,   // token_kind
    output logic        m_tlast    // run_last
);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                in_eoi_reg;
    jtl_pkg::jtl_mode_t  mode_reg;
    jtl_pkg::jtl_mode_t  mode_next;
    jtl_pkg::jtl_batch_t batch;
    logic                can_load;
    logic                advance;

    assign advance  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= jtl_pkg::MODE_IDLE;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                mode_reg <= mode_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_eoi_reg  <= s_tlast;
        end
    end

    jtl_decode u_decode (
        .mode         (mode_reg),
        .data_byte    (in_byte_reg),
        .end_of_input (in_eoi_reg),
        .mode_next    (mode_next),
        .batch        (batch)
    );

    jtl_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .batch    (batch),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
